/* rtl/txcs_pkg.sv */
// Shared types and constants for the telemetry transmit copy scheduler.
// Used by txcs_core, telemetry_tx_copy_scheduler and the testbench; no dependencies.
package txcs_pkg;

  // Internal time and counter widths; ports stay at the field widths.
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 32;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_TX_PERIOD    = 2'd0;
  localparam logic [1:0] REG_MAX_AIR_TIME = 2'd1;
  localparam logic [1:0] REG_DUP_DELAY    = 2'd2;
  localparam logic [1:0] REG_COPIES       = 2'd3;

  // Reset values of the registers.
  localparam logic [15:0] TX_PERIOD_RST    = 16'd500;
  localparam logic [15:0] MAX_AIR_TIME_RST = 16'd100;
  localparam logic [15:0] DUP_DELAY_RST    = 16'd20;
  localparam logic [1:0]  COPIES_RST       = 2'd2;

  // start_copy codes.
  localparam logic [1:0] START_NONE   = 2'd0;
  localparam logic [1:0] START_FIRST  = 2'd1;
  localparam logic [1:0] START_SECOND = 2'd2;

  // phase codes as seen on the result word.
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_COPY1 = 2'd1;
  localparam logic [1:0] PHASE_GAP   = 2'd2;
  localparam logic [1:0] PHASE_COPY2 = 2'd3;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [15:0] tx_period;
    logic [15:0] max_air_time;
    logic [15:0] dup_delay;
    logic [1:0]  copies;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        radio_ok;
    logic        tx_done;
    logic        radio_accepts;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  start_copy;
    logic        sent_report;
    logic [31:0] packet_number;
    logic [31:0] last_air_time;
    logic [31:0] busy_count;
    logic [31:0] timeout_count;
    logic [31:0] fallback_count;
  } result_t;

endpackage

/* rtl/txcs_core.sv */
// Scheduler state and the per-word phase step (idle, first copy, gap, second copy).
// Depends on txcs_pkg for cfg_t, item_t, result_t and the code constants.
module txcs_core (
  input  logic              clk,
  input  logic              rst,
  input  txcs_pkg::cfg_t    cfg,
  input  logic              step,
  input  txcs_pkg::item_t   item,
  output txcs_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_COPY1 = 2'd1,
    PH_GAP   = 2'd2,
    PH_COPY2 = 2'd3
  } phase_t;

  phase_t          phase, phase_next;
  txcs_pkg::time_t copy_start_time, copy_start_time_next;
  txcs_pkg::time_t gap_start_time, gap_start_time_next;
  txcs_pkg::time_t next_send_base, next_send_base_next;
  logic            done_latched, done_latched_next;
  txcs_pkg::count_t packet_counter, packet_counter_next;
  txcs_pkg::time_t  air_time, air_time_next;
  txcs_pkg::count_t busy_counter, busy_counter_next;
  txcs_pkg::count_t timeout_counter, timeout_counter_next;
  txcs_pkg::count_t fallback_counter, fallback_counter_next;

  txcs_pkg::time_t now, el_copy, el_gap, el_base, base_adv, el_adv;
  txcs_pkg::time_t period, air_max, air_limit, delay;
  logic            done_eff, air_expired, timed_out;
  logic [1:0]      start_copy;
  logic            sent_report;

  assign now       = txcs_pkg::TIME_BITS'(item.now_ms);
  assign period    = txcs_pkg::TIME_BITS'(cfg.tx_period);
  assign air_max   = txcs_pkg::TIME_BITS'(cfg.max_air_time);
  // abandon threshold is four air times (18 bits wide)
  assign air_limit = txcs_pkg::TIME_BITS'({cfg.max_air_time, 2'b00});
  assign delay     = txcs_pkg::TIME_BITS'(cfg.dup_delay);
  assign done_eff  = done_latched | item.tx_done;
  assign el_copy   = now - copy_start_time;
  assign el_gap    = now - gap_start_time;
  assign el_base   = now - next_send_base;
  assign base_adv  = next_send_base + period;
  assign el_adv    = now - base_adv;
  assign air_expired = el_copy >= air_max;
  assign timed_out = ((phase == PH_COPY1) || (phase == PH_COPY2)) &&
                     (el_copy > air_limit);

  always_comb begin
    phase_next            = phase;
    copy_start_time_next  = copy_start_time;
    gap_start_time_next   = gap_start_time;
    next_send_base_next   = next_send_base;
    done_latched_next     = done_eff;
    packet_counter_next   = packet_counter;
    air_time_next         = air_time;
    busy_counter_next     = busy_counter;
    timeout_counter_next  = timeout_counter;
    fallback_counter_next = fallback_counter;
    start_copy            = txcs_pkg::START_NONE;
    sent_report           = 1'b0;

    if (item.radio_ok) begin
      if (timed_out) begin
        timeout_counter_next = timeout_counter + 1'b1;
        phase_next           = PH_IDLE;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            if (el_base >= period) begin
              // catch up: jump to now if still an interval or more behind
              next_send_base_next = (el_adv >= period) ? now : base_adv;
              packet_counter_next = packet_counter + 1'b1;
              if (item.radio_accepts) begin
                done_latched_next    = 1'b0;
                copy_start_time_next = now;
                phase_next           = PH_COPY1;
                start_copy           = txcs_pkg::START_FIRST;
              end else begin
                busy_counter_next = busy_counter + 1'b1;
              end
            end
          end
          PH_COPY1: begin
            if (done_eff || air_expired) begin
              if (!done_eff) fallback_counter_next = fallback_counter + 1'b1;
              air_time_next = el_copy;
              if (!cfg.copies[1]) begin
                phase_next  = PH_IDLE;
                sent_report = 1'b1;
              end else begin
                gap_start_time_next = now;
                phase_next          = PH_GAP;
              end
            end
          end
          PH_GAP: begin
            if (el_gap >= delay) begin
              if (item.radio_accepts) begin
                done_latched_next    = 1'b0;
                copy_start_time_next = now;
                phase_next           = PH_COPY2;
                start_copy           = txcs_pkg::START_SECOND;
              end else begin
                busy_counter_next = busy_counter + 1'b1;
                phase_next        = PH_IDLE;
              end
            end
          end
          PH_COPY2: begin
            if (done_eff || air_expired) begin
              if (!done_eff) fallback_counter_next = fallback_counter + 1'b1;
              phase_next  = PH_IDLE;
              sent_report = 1'b1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    result.phase          = 2'(phase_next);
    result.start_copy     = start_copy;
    result.sent_report    = sent_report;
    result.packet_number  = 32'(packet_counter_next);
    result.last_air_time  = 32'(air_time_next);
    result.busy_count     = 32'(busy_counter_next);
    result.timeout_count  = 32'(timeout_counter_next);
    result.fallback_count = 32'(fallback_counter_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      copy_start_time  <= '0;
      gap_start_time   <= '0;
      next_send_base   <= '0;
      done_latched     <= 1'b0;
      packet_counter   <= '0;
      air_time         <= '0;
      busy_counter     <= '0;
      timeout_counter  <= '0;
      fallback_counter <= '0;
    end else if (step) begin
      phase            <= phase_next;
      copy_start_time  <= copy_start_time_next;
      gap_start_time   <= gap_start_time_next;
      next_send_base   <= next_send_base_next;
      done_latched     <= done_latched_next;
      packet_counter   <= packet_counter_next;
      air_time         <= air_time_next;
      busy_counter     <= busy_counter_next;
      timeout_counter  <= timeout_counter_next;
      fallback_counter <= fallback_counter_next;
    end
  end

`ifndef SYNTHESIS
  // state only moves on a step
  a_hold_packet: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(packet_counter))
    else $error("packet counter changed without a step");

  // a copy is started only from idle or gap
  a_start_src: assert property (@(posedge clk) disable iff (rst)
    step && (start_copy != txcs_pkg::START_NONE) |-> (phase == PH_IDLE || phase == PH_GAP))
    else $error("copy started from a copy phase");

  // starting a copy clears the done latch
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (start_copy != txcs_pkg::START_NONE) |-> !done_latched_next)
    else $error("done latch kept across a copy start");
`endif

endmodule

/* rtl/telemetry_tx_copy_scheduler.sv */
// Top level of the telemetry transmit copy scheduler: register port,
// input register and result register around txcs_core. Depends on txcs_pkg.
// Usage:
//   item channel (item_valid / item_stall / item): one word per service call
//     with the ms time, radio present flag, latched tx-done pulse and
//     whether the radio would start a packet now.
//   result channel (result_valid / result_stall / result): one word per
//     item: phase after the step, copy start code, report pulse and the
//     packet, air-time, busy, timeout and fallback counters.
//   register port (APB style, pready always high): tx_period at 0x0,
//     max_air_time at 0x4, dup_delay at 0x8, copies at 0xC. Write only
//     while no word is in flight.
// Timing: a word taken into the input register is stepped into the result
//   register once that register can load, and shows on result from then on.
//   One word per cycle sustained while result is not stalled; the step is a
//   single pass of compares and adds on the state registers.
// Stall: while result is stalled the result register holds; the input
//   register still takes one more word, then item_stall rises.
// Reset (rst, synchronous): both stages empty, registers to defaults
//   (500, 100, 20, 2), scheduler idle with all times and counters at zero.
module telemetry_tx_copy_scheduler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [txcs_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [txcs_pkg::DATA_BITS-1:0]   pwdata,
  output logic [txcs_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  txcs_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output txcs_pkg::result_t                result
);

  txcs_pkg::cfg_t    cfg;
  txcs_pkg::item_t   in_item;
  txcs_pkg::result_t core_result;
  logic              in_full;
  logic              advance;   // result register can load this cycle
  logic              step;      // input word moves into the result register
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      txcs_pkg::REG_TX_PERIOD:    prdata = 32'(cfg.tx_period);
      txcs_pkg::REG_MAX_AIR_TIME: prdata = 32'(cfg.max_air_time);
      txcs_pkg::REG_DUP_DELAY:    prdata = 32'(cfg.dup_delay);
      txcs_pkg::REG_COPIES:       prdata = 32'(cfg.copies);
      default:                    prdata = '0;
    endcase
  end

  assign advance    = ~result_valid | ~result_stall;
  assign step       = in_full & advance;
  assign item_stall = in_full & ~advance;

  txcs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (in_item),
    .result (core_result)
  );

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full          <= 1'b0;
      result_valid     <= 1'b0;
      cfg.tx_period    <= txcs_pkg::TX_PERIOD_RST;
      cfg.max_air_time <= txcs_pkg::MAX_AIR_TIME_RST;
      cfg.dup_delay    <= txcs_pkg::DUP_DELAY_RST;
      cfg.copies       <= txcs_pkg::COPIES_RST;
    end else begin
      if (!item_stall) in_full <= item_valid;
      if (advance) result_valid <= in_full;
      if (wr_en) begin
        unique case (reg_idx)
          txcs_pkg::REG_TX_PERIOD:    cfg.tx_period    <= pwdata[15:0];
          txcs_pkg::REG_MAX_AIR_TIME: cfg.max_air_time <= pwdata[15:0];
          txcs_pkg::REG_DUP_DELAY:    cfg.dup_delay    <= pwdata[15:0];
          txcs_pkg::REG_COPIES:       cfg.copies       <= pwdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) in_item <= item;
    if (step) result <= core_result;
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !in_full)
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_full && result_valid)
    else $error("input stalled with room downstream");

  a_moves_on: assert property (@(posedge clk) disable iff (rst)
    in_full && !result_valid |=> result_valid)
    else $error("buffered word did not reach the result register");

  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sent_report |->
      result.phase == txcs_pkg::PHASE_IDLE && result.start_copy == txcs_pkg::START_NONE)
    else $error("report with a copy still active");
`endif

endmodule

/* test/txcs_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for telemetry_tx_copy_scheduler: mirrors register writes, steps its own
// model of the scheduler for each accepted item word and checks each result word.
// Depends on txcs_pkg.
module txcs_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [txcs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [txcs_pkg::DATA_BITS-1:0] pwdata,
  input  logic                           pready,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  txcs_pkg::item_t                item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  txcs_pkg::result_t              result,
  output int                             mismatch_count,
  output int                             words_outstanding,
  output int                             words_stepped,
  output int                             report_count,
  output int                             timeout_seen
);

  txcs_pkg::cfg_t   cfg_q;
  logic [1:0]       phase_q;
  txcs_pkg::time_t  copy_start_q;
  txcs_pkg::time_t  gap_start_q;
  txcs_pkg::time_t  send_base_q;
  logic             done_q;
  txcs_pkg::count_t packets_q;
  txcs_pkg::count_t air_q;
  txcs_pkg::count_t busy_q;
  txcs_pkg::count_t timeouts_q;
  txcs_pkg::count_t fallbacks_q;

  txcs_pkg::result_t expected_results[$];

  // One service call of the scheduler; updates the model state.
  task automatic step_scheduler(input txcs_pkg::item_t w, output txcs_pkg::result_t r);
    logic [1:0]      started;
    logic            reported;
    logic            finished;
    txcs_pkg::time_t since_copy;
    txcs_pkg::time_t since_base;
    txcs_pkg::time_t timeout_lim;
    started     = txcs_pkg::START_NONE;
    reported    = 1'b0;
    since_copy  = w.now_ms - copy_start_q;
    timeout_lim = {14'd0, cfg_q.max_air_time, 2'b00};
    if (w.tx_done) done_q = 1'b1;
    if (w.radio_ok) begin
      finished = done_q || (since_copy >= {16'd0, cfg_q.max_air_time});
      if ((phase_q == txcs_pkg::PHASE_COPY1 || phase_q == txcs_pkg::PHASE_COPY2) &&
          since_copy > timeout_lim) begin
        timeouts_q = timeouts_q + 1'b1;
        phase_q    = txcs_pkg::PHASE_IDLE;
      end else begin
        case (phase_q)
          txcs_pkg::PHASE_IDLE: begin
            since_base = w.now_ms - send_base_q;
            if (since_base >= {16'd0, cfg_q.tx_period}) begin
              send_base_q = send_base_q + {16'd0, cfg_q.tx_period};
              since_base  = w.now_ms - send_base_q;
              // still a full interval behind: resync to now
              if (since_base >= {16'd0, cfg_q.tx_period}) send_base_q = w.now_ms;
              packets_q = packets_q + 1'b1;
              if (w.radio_accepts) begin
                done_q       = 1'b0;
                copy_start_q = w.now_ms;
                phase_q      = txcs_pkg::PHASE_COPY1;
                started      = txcs_pkg::START_FIRST;
              end else begin
                busy_q = busy_q + 1'b1;
              end
            end
          end
          txcs_pkg::PHASE_COPY1: begin
            if (finished) begin
              if (!done_q) fallbacks_q = fallbacks_q + 1'b1;
              air_q = since_copy;
              if (cfg_q.copies < 2'd2) begin
                phase_q  = txcs_pkg::PHASE_IDLE;
                reported = 1'b1;
              end else begin
                gap_start_q = w.now_ms;
                phase_q     = txcs_pkg::PHASE_GAP;
              end
            end
          end
          txcs_pkg::PHASE_GAP: begin
            if (w.now_ms - gap_start_q >= {16'd0, cfg_q.dup_delay}) begin
              if (w.radio_accepts) begin
                done_q       = 1'b0;
                copy_start_q = w.now_ms;
                phase_q      = txcs_pkg::PHASE_COPY2;
                started      = txcs_pkg::START_SECOND;
              end else begin
                busy_q  = busy_q + 1'b1;
                phase_q = txcs_pkg::PHASE_IDLE;
              end
            end
          end
          default: begin
            if (finished) begin
              if (!done_q) fallbacks_q = fallbacks_q + 1'b1;
              phase_q  = txcs_pkg::PHASE_IDLE;
              reported = 1'b1;
            end
          end
        endcase
      end
    end
    r.phase          = phase_q;
    r.start_copy     = started;
    r.sent_report    = reported;
    r.packet_number  = packets_q;
    r.last_air_time  = air_q;
    r.busy_count     = busy_q;
    r.timeout_count  = timeouts_q;
    r.fallback_count = fallbacks_q;
  endtask

  always @(posedge clk) begin : watch
    txcs_pkg::result_t want;
    txcs_pkg::result_t fresh;
    logic              bad;
    if (rst) begin
      cfg_q.tx_period    = txcs_pkg::TX_PERIOD_RST;
      cfg_q.max_air_time = txcs_pkg::MAX_AIR_TIME_RST;
      cfg_q.dup_delay    = txcs_pkg::DUP_DELAY_RST;
      cfg_q.copies       = txcs_pkg::COPIES_RST;
      phase_q      = txcs_pkg::PHASE_IDLE;
      copy_start_q = '0;
      gap_start_q  = '0;
      send_base_q  = '0;
      done_q       = 1'b0;
      packets_q    = '0;
      air_q        = '0;
      busy_q       = '0;
      timeouts_q   = '0;
      fallbacks_q  = '0;
      expected_results.delete();
      words_outstanding <= 0;
      mismatch_count    <= 0;
      words_stepped     <= 0;
      report_count      <= 0;
      timeout_seen      <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          txcs_pkg::REG_TX_PERIOD:    cfg_q.tx_period    = pwdata[15:0];
          txcs_pkg::REG_MAX_AIR_TIME: cfg_q.max_air_time = pwdata[15:0];
          txcs_pkg::REG_DUP_DELAY:    cfg_q.dup_delay    = pwdata[15:0];
          txcs_pkg::REG_COPIES:       cfg_q.copies       = pwdata[1:0];
          default: ;
        endcase
      end
      // result first: a word accepted at this edge cannot have produced it
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result word with nothing expected: %h", $time, result);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          bad  = (result.phase !== want.phase) || (result.start_copy !== want.start_copy) ||
                 (result.sent_report !== want.sent_report) ||
                 (result.packet_number !== want.packet_number) ||
                 (result.last_air_time !== want.last_air_time) ||
                 (result.busy_count !== want.busy_count) ||
                 (result.timeout_count !== want.timeout_count) ||
                 (result.fallback_count !== want.fallback_count);
          if (bad) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch (expected / actual)", $time);
              $display("  phase %0d/%0d start %0d/%0d report %0d/%0d packets %0d/%0d",
                       want.phase, result.phase, want.start_copy, result.start_copy,
                       want.sent_report, result.sent_report,
                       want.packet_number, result.packet_number);
              $display("  air %0d/%0d busy %0d/%0d timeouts %0d/%0d fallbacks %0d/%0d",
                       want.last_air_time, result.last_air_time,
                       want.busy_count, result.busy_count,
                       want.timeout_count, result.timeout_count,
                       want.fallback_count, result.fallback_count);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (item_valid && !item_stall) begin
        step_scheduler(item, fresh);
        expected_results.push_back(fresh);
        words_stepped <= words_stepped + 1;
        if (fresh.sent_report) report_count <= report_count + 1;
        timeout_seen <= int'(timeouts_q);
      end
      words_outstanding <= expected_results.size();
    end
  end

endmodule

/* test/telemetry_tx_copy_scheduler_test.sv */
`timescale 1ns / 1ps
// Top of the telemetry_tx_copy_scheduler testbench: clock, reset, register writes,
// item and result traffic, watchdog and verdict. Depends on txcs_pkg, txcs_checker and telemetry_tx_copy_scheduler.
module telemetry_tx_copy_scheduler_test;

  localparam int NUM_PHASES      = 9;
  localparam int WORDS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 40;    // long receiver hold-off
  localparam int DRAIN_CYCLES    = 4;     // input and result registers plus margin
  localparam int QUIET_LIMIT     = 2000;  // cycles with no word moving

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [txcs_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [txcs_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [txcs_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  txcs_pkg::item_t                item = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  txcs_pkg::result_t              result;

  int mismatch_count;
  int words_outstanding;
  int words_stepped;
  int report_count;
  int timeout_seen;

  // Handshake between the stimulus and the two side processes.
  int hold_reqs  = 0;      // long hold-offs asked of the receiver so far
  int burst_left = 0;      // sender words still to go with no gap
  int quiet_cycles = 0;
  txcs_pkg::time_t clock_ms = '0;    // running millisecond time for random words

  always #2 clk = ~clk;

  telemetry_tx_copy_scheduler u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  txcs_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .item              (item),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result            (result),
    .mismatch_count    (mismatch_count),
    .words_outstanding (words_outstanding),
    .words_stepped     (words_stepped),
    .report_count      (report_count),
    .timeout_seen      (timeout_seen)
  );

  function automatic txcs_pkg::item_t mk(logic [31:0] now, logic ok, logic done, logic acc);
    txcs_pkg::item_t w;
    w.now_ms        = now;
    w.radio_ok      = ok;
    w.tx_done       = done;
    w.radio_accepts = acc;
    return w;
  endfunction

  // Offer one item word after a random gap; returns once it is taken.
  // With no gap, valid simply stays high into the next word.
  task automatic send_item(input txcs_pkg::item_t w);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall);
  endtask

  // APB write: setup, then access; pready is tied high.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering, wait for every expected result, then let the pipe drain.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall per result, fast stretches, and one long hold-off
  // on request so the block backs up into item_stall.
  initial begin : result_side
    int wait_cycles;
    int fast_left;
    int holds_done;
    fast_left  = 0;
    holds_done = 0;
    forever begin
      if (holds_done != hold_reqs) begin
        wait_cycles = HOLD_CYCLES;
        holds_done  = hold_reqs;
      end else if (fast_left > 0) begin
        wait_cycles = 0;
        fast_left--;
      end else begin
        wait_cycles = $urandom_range(0, 9);
        if ($urandom_range(0, 29) == 0) fast_left = $urandom_range(10, 40);
      end
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Watchdog: any cycle without a word moving on either channel counts.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    txcs_pkg::cfg_t  settings [NUM_PHASES];
    int              scale;
    int              span;
    int              pick;
    txcs_pkg::item_t w;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk under reset settings (500 / 100 / 20 / 2 copies).
    send_item(mk(32'd0, 1'b1, 1'b0, 1'b1));           // not due yet
    send_item(mk(32'd600, 1'b0, 1'b1, 1'b1));         // radio absent: only latches done
    send_item(mk(32'd600, 1'b1, 1'b0, 1'b0));         // due, radio refuses: busy
    send_item(mk(32'd1000, 1'b1, 1'b0, 1'b1));        // first copy starts, latch cleared
    send_item(mk(32'd1010, 1'b1, 1'b1, 1'b1));        // done pulse ends copy 1 -> gap
    send_item(mk(32'd1020, 1'b1, 1'b0, 1'b1));        // gap not over
    send_item(mk(32'd1030, 1'b1, 1'b0, 1'b0));        // second copy refused -> idle
    send_item(mk(32'd1500, 1'b1, 1'b0, 1'b1));        // next packet
    send_item(mk(32'd1600, 1'b1, 1'b0, 1'b1));        // air-time fallback
    send_item(mk(32'd1620, 1'b1, 1'b0, 1'b1));        // second copy starts
    send_item(mk(32'd2100, 1'b1, 1'b0, 1'b1));        // past 4x air time: timeout
    send_item(mk(32'd2101, 1'b1, 1'b0, 1'b1));        // schedule advances, new packet
    send_item(mk(32'd2150, 1'b1, 1'b1, 1'b1));
    send_item(mk(32'd2170, 1'b1, 1'b0, 1'b1));        // second copy
    send_item(mk(32'd2180, 1'b0, 1'b1, 1'b0));        // done latched while radio absent
    send_item(mk(32'd2181, 1'b1, 1'b0, 1'b0));        // latched done completes -> report
    send_item(mk(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));   // far behind: schedule catch-up
    send_item(mk(32'h0000_0005, 1'b1, 1'b1, 1'b1));   // time wraps
    send_item(mk(32'h0000_0019, 1'b1, 1'b0, 1'b1));
    send_item(mk(32'h0000_007D, 1'b1, 1'b0, 1'b1));   // fallback on copy 2 -> report
    send_item(mk(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));   // all ones, radio absent
    send_item(mk(32'h0000_0000, 1'b1, 1'b1, 1'b0));

    // Register settings: moderate, both extremes, zero interval, odd copies values.
    settings[0] = '{tx_period: 16'd50,    max_air_time: 16'd20,
                    dup_delay: 16'd5,     copies: 2'd2};
    settings[1] = '{tx_period: 16'd1,     max_air_time: 16'd1,
                    dup_delay: 16'd0,     copies: 2'd1};
    settings[2] = '{tx_period: 16'hFFFF,  max_air_time: 16'hFFFF,
                    dup_delay: 16'hFFFF,  copies: 2'd2};
    settings[3] = '{tx_period: 16'd0,     max_air_time: 16'd10,
                    dup_delay: 16'd3,     copies: 2'd2};
    settings[4] = '{tx_period: 16'd30,    max_air_time: 16'd8,
                    dup_delay: 16'd0,     copies: 2'd3};
    settings[5] = '{tx_period: 16'd40,    max_air_time: 16'd15,
                    dup_delay: 16'd10,    copies: 2'd0};
    settings[6] = '{tx_period: 16'($urandom_range(1, 300)),
                    max_air_time: 16'($urandom_range(1, 80)),
                    dup_delay: 16'($urandom_range(0, 60)),
                    copies: 2'($urandom_range(1, 2))};
    settings[7] = '{tx_period: 16'($urandom_range(1, 2000)),
                    max_air_time: 16'($urandom_range(1, 400)),
                    dup_delay: 16'($urandom_range(0, 300)),
                    copies: 2'($urandom_range(1, 2))};
    settings[8] = '{tx_period: txcs_pkg::TX_PERIOD_RST,
                    max_air_time: txcs_pkg::MAX_AIR_TIME_RST,
                    dup_delay: txcs_pkg::DUP_DELAY_RST, copies: txcs_pkg::COPIES_RST};

    for (int p = 0; p < NUM_PHASES; p++) begin
      // registers change only with nothing in flight
      settle();
      apb_write(txcs_pkg::REG_TX_PERIOD,    {16'd0, settings[p].tx_period});
      apb_write(txcs_pkg::REG_MAX_AIR_TIME, {16'd0, settings[p].max_air_time});
      apb_write(txcs_pkg::REG_DUP_DELAY,    {16'd0, settings[p].dup_delay});
      apb_write(txcs_pkg::REG_COPIES,       {30'd0, settings[p].copies});

      // time steps sized so schedule, air time and gap all get crossed
      span = int'(settings[p].tx_period);
      if (4 * int'(settings[p].max_air_time) > span) span = 4 * int'(settings[p].max_air_time);
      if (int'(settings[p].dup_delay) > span) span = int'(settings[p].dup_delay);
      scale = span / 6 + 1;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // long receiver hold-off with the sender pushing back-to-back
        if (n == 40 && (p == 0 || p == 6)) begin
          hold_reqs  = hold_reqs + 1;
          burst_left = 30;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
          clock_ms = $urandom;                          // noise: any time at all
        else if (pick < 8)
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * scale);
        else if (pick < 18)
          clock_ms = clock_ms + $urandom_range(4 * scale, 12 * scale + 8);
        else if (pick < 33)
          clock_ms = clock_ms + $urandom_range(0, 2);
        else
          clock_ms = clock_ms + $urandom_range(0, scale);
        w.now_ms        = clock_ms;
        w.radio_ok      = ($urandom_range(0, 99) < 90);
        w.tx_done       = ($urandom_range(0, 99) < 20);
        w.radio_accepts = ($urandom_range(0, 99) < 85);
        send_item(w);
      end
    end

    settle();
    $display("Stepped %0d service calls over %0d register settings and reset values;",
             words_stepped, NUM_PHASES);
    $display("%0d packet reports and %0d copy timeouts seen, with back-pressure hold-offs.",
             report_count, timeout_seen);
    if (mismatch_count == 0 && words_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, words_outstanding);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
